@@ rtl/core/qse_pkg.sv @@
// qse_pkg: shared types, constants and helpers of the quicksort engine.
// No dependencies; used by every module of the block.
package qse_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_ITEMS_DEF = 64;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_POPW,
		ST_PIV,
		ST_CNT,
		ST_SWP0,
		ST_SWP1,
		ST_SWP2,
		ST_PART,
		ST_SI,
		ST_SJ,
		ST_SW1,
		ST_SW2,
		ST_PUSH1,
		ST_PUSH2,
		ST_EMRD,
		ST_EMLD
	} qse_state_t;

	typedef struct packed {
		logic load;
		logic last;
	} qse_emit_t;

	// signed a <= b
	function automatic logic key_le(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		return $signed(a) <= $signed(b);
	endfunction

endpackage

@@ rtl/core/qse_ram.sv @@
// qse_ram: simple dual-port synchronous memory, one write and one registered read.
// Depends on qse_pkg for its parameter defaults; used for the element store and the range stack.
module qse_ram #(
	parameter int DEPTH = qse_pkg::MAX_ITEMS_DEF,
	parameter int WIDTH = qse_pkg::DATA_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/qse_ctrl.sv @@
// qse_ctrl: load, quicksort sequencer and emit sequencing over the two memories.
// Depends on qse_pkg; drives the ports of two qse_ram instances.
module qse_ctrl #(
	parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [qse_pkg::DATA_W-1:0]  in_value,
	input  logic                        in_last,
	output logic                        in_ready,
	input  logic                        out_full,
	output qse_pkg::qse_emit_t          emit,
	output logic                        st_we,
	output logic [$clog2(MAX_ITEMS)-1:0] st_waddr,
	output logic [qse_pkg::DATA_W-1:0]  st_wdata,
	output logic [$clog2(MAX_ITEMS)-1:0] st_raddr,
	input  logic [qse_pkg::DATA_W-1:0]  st_rdata,
	output logic                        rs_we,
	output logic [$clog2(MAX_ITEMS)-1:0] rs_waddr,
	output logic [2*$clog2(MAX_ITEMS)-1:0] rs_wdata,
	output logic [$clog2(MAX_ITEMS)-1:0] rs_raddr,
	input  logic [2*$clog2(MAX_ITEMS)-1:0] rs_rdata
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

	qse_pkg::qse_state_t state_q, state_d;

	logic [CW-1:0] count_q, sp_q;
	logic [AW-1:0] lo_q, hi_q, k_q, cnt_q, p_q, i_q, j_q, e_q;
	logic [qse_pkg::DATA_W-1:0] pivot_q, di_q, dj_q;

	logic          le;
	logic [AW-1:0] cnt_n;
	logic          i_lt_p, j_gt_p, i1_lt_p, j1_gt_p;
	logic          push_lo, push_hi, sp_room;
	logic          in_fire, emit_last;
	logic [AW-1:0] pop_lo, pop_hi;

	assign le        = qse_pkg::key_le(st_rdata, pivot_q);
	assign cnt_n     = cnt_q + AW'(le);
	assign i_lt_p    = i_q < p_q;
	assign j_gt_p    = j_q > p_q;
	assign i1_lt_p   = ({1'b0, i_q} + 1'b1) < {1'b0, p_q};
	assign j1_gt_p   = {1'b0, j_q} > ({1'b0, p_q} + 1'b1);
	assign push_lo   = {1'b0, p_q} > ({1'b0, lo_q} + 1'b1);
	assign push_hi   = {1'b0, hi_q} > ({1'b0, p_q} + 1'b1);
	assign sp_room   = sp_q < CNT_MAX;
	assign in_fire   = in_valid && in_ready;
	assign emit_last = CW'(e_q) == (count_q - CW'(1));
	assign pop_lo    = rs_rdata[2*AW-1:AW];
	assign pop_hi    = rs_rdata[AW-1:0];
	assign in_ready  = state_q == qse_pkg::ST_LOAD;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qse_pkg::ST_LOAD:  if (in_fire && in_last) state_d = qse_pkg::ST_INIT;
			qse_pkg::ST_INIT:  state_d = (count_q < CW'(2)) ? qse_pkg::ST_EMRD : qse_pkg::ST_POP;
			qse_pkg::ST_POP:   state_d = (sp_q == '0) ? qse_pkg::ST_EMRD : qse_pkg::ST_POPW;
			qse_pkg::ST_POPW:  state_d = (pop_lo >= pop_hi) ? qse_pkg::ST_POP : qse_pkg::ST_PIV;
			qse_pkg::ST_PIV:   state_d = qse_pkg::ST_CNT;
			qse_pkg::ST_CNT:   if (k_q == hi_q) state_d = qse_pkg::ST_SWP0;
			qse_pkg::ST_SWP0:  state_d = qse_pkg::ST_SWP1;
			qse_pkg::ST_SWP1:  state_d = qse_pkg::ST_SWP2;
			qse_pkg::ST_SWP2:  state_d = qse_pkg::ST_PART;
			qse_pkg::ST_PART:  state_d = (i_lt_p && j_gt_p) ? qse_pkg::ST_SI : qse_pkg::ST_PUSH1;
			qse_pkg::ST_SI: begin
				if (!le) state_d = qse_pkg::ST_SJ;
				else if (!i1_lt_p) state_d = qse_pkg::ST_PUSH1;
			end
			qse_pkg::ST_SJ: begin
				if (le) state_d = qse_pkg::ST_SW1;
				else if (!j1_gt_p) state_d = qse_pkg::ST_PUSH1;
			end
			qse_pkg::ST_SW1:   state_d = qse_pkg::ST_SW2;
			qse_pkg::ST_SW2:   state_d = qse_pkg::ST_PART;
			qse_pkg::ST_PUSH1: state_d = qse_pkg::ST_PUSH2;
			qse_pkg::ST_PUSH2: state_d = qse_pkg::ST_POP;
			qse_pkg::ST_EMRD:  if (!out_full) state_d = qse_pkg::ST_EMLD;
			qse_pkg::ST_EMLD:  state_d = emit_last ? qse_pkg::ST_LOAD : qse_pkg::ST_EMRD;
			default:           state_d = qse_pkg::ST_LOAD;
		endcase
	end

	// memory ports and emit strobe
	always_comb begin
		st_we     = 1'b0;
		st_waddr  = i_q;
		st_wdata  = dj_q;
		st_raddr  = i_q;
		rs_we     = 1'b0;
		rs_waddr  = sp_q[AW-1:0];
		rs_wdata  = {lo_q, AW'(p_q - 1'b1)};
		rs_raddr  = AW'(sp_q - CW'(1));
		emit.load = 1'b0;
		emit.last = emit_last;
		unique case (state_q)
			qse_pkg::ST_LOAD: begin
				st_we    = in_fire && (count_q < CNT_MAX);
				st_waddr = count_q[AW-1:0];
				st_wdata = in_value;
			end
			qse_pkg::ST_INIT: begin
				rs_we    = count_q >= CW'(2);
				rs_waddr = '0;
				rs_wdata = {AW'(0), AW'(count_q - CW'(1))};
			end
			qse_pkg::ST_POPW:  st_raddr = pop_lo;
			qse_pkg::ST_PIV:   st_raddr = lo_q + 1'b1;
			qse_pkg::ST_CNT:   st_raddr = k_q + 1'b1;
			qse_pkg::ST_SWP0:  st_raddr = p_q;
			qse_pkg::ST_SWP1: begin
				st_we    = 1'b1;
				st_waddr = lo_q;
				st_wdata = st_rdata;
			end
			qse_pkg::ST_SWP2: begin
				st_we    = 1'b1;
				st_waddr = p_q;
				st_wdata = pivot_q;
			end
			qse_pkg::ST_PART:  st_raddr = i_q;
			qse_pkg::ST_SI:    st_raddr = le ? i_q + 1'b1 : j_q;
			qse_pkg::ST_SJ:    st_raddr = j_q - 1'b1;
			qse_pkg::ST_SW1: begin
				st_we    = 1'b1;
				st_waddr = i_q;
				st_wdata = dj_q;
			end
			qse_pkg::ST_SW2: begin
				st_we    = 1'b1;
				st_waddr = j_q;
				st_wdata = di_q;
			end
			qse_pkg::ST_PUSH1: rs_we = push_lo && sp_room;
			qse_pkg::ST_PUSH2: begin
				rs_we    = push_hi && sp_room;
				rs_wdata = {AW'(p_q + 1'b1), hi_q};
			end
			qse_pkg::ST_EMRD:  st_raddr = e_q;
			qse_pkg::ST_EMLD:  emit.load = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qse_pkg::ST_LOAD;
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				qse_pkg::ST_LOAD:  if (in_fire && count_q < CNT_MAX) count_q <= count_q + 1'b1;
				qse_pkg::ST_INIT:  sp_q <= (count_q >= CW'(2)) ? CW'(1) : '0;
				qse_pkg::ST_POP:   if (sp_q != '0) sp_q <= sp_q - 1'b1;
				qse_pkg::ST_PUSH1: if (push_lo && sp_room) sp_q <= sp_q + 1'b1;
				qse_pkg::ST_PUSH2: if (push_hi && sp_room) sp_q <= sp_q + 1'b1;
				qse_pkg::ST_EMLD: begin
					if (emit_last) begin
						count_q <= '0;
						sp_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			qse_pkg::ST_INIT: e_q <= '0;
			qse_pkg::ST_POPW: begin
				lo_q <= pop_lo;
				hi_q <= pop_hi;
			end
			qse_pkg::ST_PIV: begin
				pivot_q <= st_rdata;
				k_q     <= lo_q + 1'b1;
				cnt_q   <= '0;
			end
			qse_pkg::ST_CNT: begin
				cnt_q <= cnt_n;
				k_q   <= k_q + 1'b1;
				if (k_q == hi_q) p_q <= lo_q + cnt_n;
			end
			qse_pkg::ST_SWP2: begin
				i_q <= lo_q;
				j_q <= hi_q;
			end
			qse_pkg::ST_SI: begin
				if (le) i_q <= i_q + 1'b1;
				else di_q <= st_rdata;
			end
			qse_pkg::ST_SJ: begin
				if (!le) j_q <= j_q - 1'b1;
				else dj_q <= st_rdata;
			end
			qse_pkg::ST_SW2: begin
				i_q <= i_q + 1'b1;
				j_q <= j_q - 1'b1;
			end
			qse_pkg::ST_EMLD: e_q <= e_q + 1'b1;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/quicksort_engine.sv @@
// quicksort_engine: batch sorter for signed 32-bit values, top level.
// Depends on qse_pkg, qse_ram and qse_ctrl.
//
//  channel  dir  handshake          tdata                 tlast / meaning
//  s_*      in   s_tvalid/s_tready  [31:0] value          is_last, starts the sort
//  m_*      out  m_tvalid/m_tready  [31:0] sorted_value   end_of_run
//
// Loading keeps s_tready high until the item with s_tlast is taken. The sort of n items
// runs through the single read port of the element store: per partition it fetches the
// pivot, counts the elements not above it, moves the pivot into place, starts the scan,
// scans elements and exchanges pairs, with range-stack handling around each partition;
// emitting reads each item from the store and loads it into the output register.
// Reset clears control state only; the memories need no clearing pass.
// A stalled output holds the sequencer before the next store read.
module quicksort_engine #(
	parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [qse_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [qse_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic                       m_tlast
);

	localparam int AW = $clog2(MAX_ITEMS);

	logic                       st_we, rs_we;
	logic [AW-1:0]              st_waddr, st_raddr, rs_waddr, rs_raddr;
	logic [qse_pkg::DATA_W-1:0] st_wdata, st_rdata;
	logic [2*AW-1:0]            rs_wdata, rs_rdata;
	qse_pkg::qse_emit_t         emit;

	logic                       out_valid_q, out_last_q;
	logic [qse_pkg::DATA_W-1:0] out_data_q;

	qse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(qse_pkg::DATA_W)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	qse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(2*AW)) u_stack (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rs_waddr),
		.wdata (rs_wdata),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	qse_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.out_full (out_valid_q),
		.emit     (emit),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata),
		.st_raddr (st_raddr),
		.st_rdata (st_rdata),
		.rs_we    (rs_we),
		.rs_waddr (rs_waddr),
		.rs_wdata (rs_wdata),
		.rs_raddr (rs_raddr),
		.rs_rdata (rs_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_data_q <= st_rdata;
			out_last_q <= emit.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/core/qse_checker.sv @@
// qse_checker: port-level assertions for quicksort_engine.
// Depends on qse_pkg; bound to the top level below.
module qse_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       s_tlast,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [qse_pkg::DATA_W-1:0] m_tdata,
	input logic                       m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	// the last item of a batch closes the input side
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after batch end");

	// no loading while a batch is still being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input open during emission");

	// after a transfer, m_tvalid drops until a new store read has reloaded the output
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("output reloaded without store read");

endmodule

bind quicksort_engine qse_checker u_qse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
